// File: rtl/core/trbc_pkg.sv
`timescale 1ns / 1ps

package trbc_pkg;

  localparam int RING_DEPTH   = 64;
  localparam int HANDLE_WIDTH = 32;

  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CAP_W      = $clog2(RING_DEPTH + 1);
  localparam int CAP_RST    = (RING_DEPTH < 64) ? RING_DEPTH : 64;
  localparam int CFG_CAP_W  = 7;
  localparam int LEN_W      = 16;
  localparam int BYTES_W    = 22;
  localparam int ENT_W      = 6;
  localparam int HPORT_W    = 32;
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int ALU_W      = BYTES_W + 1;

  localparam logic [LEN_W-1:0] MAX_BATCH_RST = 16'd1460;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_CAP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_CPL    = 2'd1,
    CMD_GATHER = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SUM  = 2'd0,
    KIND_REL  = 2'd1,
    KIND_DESC = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_UNDERRUN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_CRD,
    S_CCMP,
    S_CPART,
    S_COFS,
    S_CREL,
    S_GRD,
    S_GSUM,
    S_GCHK,
    S_SUM
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] handle;
    logic [LEN_W-1:0]        rem;
    logic [LEN_W-1:0]        ofs;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  // ring successor, wrapping at the programmed capacity
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(idx) + 1'b1;
    return (n >= cap) ? '0 : IDX_W'(n);
  endfunction

endpackage

// File: rtl/core/trbc_if.sv
`timescale 1ns / 1ps

interface trbc_in_if import trbc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [HPORT_W-1:0]   packet_handle;
  logic [LEN_W-1:0]     packet_length;
  logic [BYTES_W-1:0]   bytes_sent;
  logic [ENT_W-1:0]     max_entries;

  modport source(output valid, command, packet_handle, packet_length, bytes_sent,
                 max_entries, input ready);
  modport sink(input valid, command, packet_handle, packet_length, bytes_sent,
               max_entries, output ready);
endinterface

interface trbc_out_if import trbc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    result_kind;
  logic [STAT_W-1:0]    status;
  logic [HPORT_W-1:0]   handle;
  logic [LEN_W-1:0]     offset;
  logic [LEN_W-1:0]     length;
  logic [ENT_W-1:0]     count;
  logic [BYTES_W-1:0]   leftover_bytes;
  logic                 last;

  modport source(output valid, result_kind, status, handle, offset, length, count,
                 leftover_bytes, last, input ready);
  modport sink(input valid, result_kind, status, handle, offset, length, count,
               leftover_bytes, last, output ready);
endinterface

interface trbc_cfg_if import trbc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/trbc_mem.sv
`timescale 1ns / 1ps

module trbc_mem import trbc_pkg::*; (
  input  logic    clk,
  input  mem_wr_t wr,
  input  mem_rd_t rd,
  output entry_t  rd_data_r
);

  // descriptor storage: handle, bytes remaining, bytes sent
  entry_t mem_r [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

endmodule

// File: rtl/core/trbc_alu.sv
`timescale 1ns / 1ps

module trbc_alu import trbc_pkg::*; (
  input  alu_req_t         req,
  output logic [ALU_W-1:0] res,
  output logic             carry
);

  logic [ALU_W:0] full;

  // carry doubles as borrow on subtract: set when a < b
  always_comb begin
    if (req.op == ALU_ADD) begin
      full = {1'b0, req.a} + {1'b0, req.b};
    end else begin
      full = {1'b0, req.a} - {1'b0, req.b};
    end
  end

  assign res   = full[ALU_W-1:0];
  assign carry = full[ALU_W];

endmodule

// File: rtl/core/tx_descriptor_ring_byte_completion.sv
// channel   dir   handshake      payload
// in_chan   in    valid/ready    command, packet_handle, packet_length, bytes_sent,
//                                max_entries
// out_chan  out   valid/ready    result_kind, status, handle, offset, length, count,
//                                leftover_bytes, last
// cfg_chan  in    valid/ready    index, data (ring_capacity, max_batch_bytes)
//
// push accepts, writes the ring and reports; complete reads and compares each head
// entry, then releases it or, on a partial send, writes back the new remaining
// bytes and offset; gather reads, sums and checks each descriptor; each ring
// entry is one memory read plus passes through the single shared adder/subtractor
// rst_n is synchronous; reset leaves an empty ring, capacity 64, batch limit 1460
// a full output register stalls the sequencer in place until out_chan.ready
`timescale 1ns / 1ps

module tx_descriptor_ring_byte_completion import trbc_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  trbc_in_if.sink      in_chan,
  trbc_out_if.source   out_chan,
  trbc_cfg_if.sink     cfg_chan
);

  // sequencer and ring pointers
  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [IDX_W-1:0]        tail_r, tail_nxt;
  logic [IDX_W-1:0]        walk_r, walk_nxt;
  logic [CAP_W-1:0]        cap_r, cap_nxt;
  logic [LEN_W-1:0]        maxb_r, maxb_nxt;

  // latched request and per-command working registers
  cmd_t                    cmd_r, cmd_nxt;
  logic [HANDLE_WIDTH-1:0] hdl_r, hdl_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [BYTES_W-1:0]      left_r, left_nxt;
  logic [ENT_W-1:0]        lim_r, lim_nxt;
  logic [ENT_W-1:0]        cnt_r, cnt_nxt;
  status_t                 stat_r, stat_nxt;
  logic [ALU_W-1:0]        total_r, total_nxt;
  logic [ALU_W-1:0]        sum_r, sum_nxt;
  logic [LEN_W-1:0]        newrem_r, newrem_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  kind_t                   out_kind_r, out_kind_nxt;
  status_t                 out_stat_r, out_stat_nxt;
  logic [HPORT_W-1:0]      out_hdl_r, out_hdl_nxt;
  logic [LEN_W-1:0]        out_ofs_r, out_ofs_nxt;
  logic [LEN_W-1:0]        out_len_r, out_len_nxt;
  logic [ENT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic [BYTES_W-1:0]      out_left_r, out_left_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_fire;
  logic                    cfg_fire;
  logic                    out_free;
  logic                    emit;
  logic [CFG_CAP_W-1:0]    cfg_cap;

  mem_wr_t                 mem_wr;
  mem_rd_t                 mem_rd;
  entry_t                  rd_data;
  alu_req_t                alu_req;
  logic [ALU_W-1:0]        alu_res;
  logic                    alu_carry;

  trbc_mem u_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .rd        (mem_rd),
    .rd_data_r (rd_data)
  );

  trbc_alu u_alu (
    .req   (alu_req),
    .res   (alu_res),
    .carry (alu_carry)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_fire       = cfg_chan.valid && cfg_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign cfg_cap        = cfg_chan.data[CFG_CAP_W-1:0];

  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_kind    = out_kind_r;
  assign out_chan.status         = out_stat_r;
  assign out_chan.handle         = out_hdl_r;
  assign out_chan.offset         = out_ofs_r;
  assign out_chan.length         = out_len_r;
  assign out_chan.count          = out_cnt_r;
  assign out_chan.leftover_bytes = out_left_r;
  assign out_chan.last           = out_last_r;

  // shared adder operand selection, one use per sequencer step
  always_comb begin
    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    unique case (state_r)
      S_CCMP: begin
        // bytes left against head packet's remaining bytes
        alu_req = '{op: ALU_SUB, a: ALU_W'(left_r), b: ALU_W'(rd_data.rem)};
      end
      S_CPART: begin
        // partial send: new remaining count
        alu_req = '{op: ALU_SUB, a: ALU_W'(rd_data.rem), b: ALU_W'(left_r)};
      end
      S_COFS: begin
        // partial send: advanced offset
        alu_req = '{op: ALU_ADD, a: ALU_W'(rd_data.ofs), b: ALU_W'(left_r)};
      end
      S_CREL: begin
        // released packet reports its full length as offset
        alu_req = '{op: ALU_ADD, a: ALU_W'(rd_data.ofs), b: ALU_W'(rd_data.rem)};
      end
      S_GSUM: begin
        alu_req = '{op: ALU_ADD, a: total_r, b: ALU_W'(rd_data.rem)};
      end
      S_GCHK: begin
        // borrow here means the batch would exceed its byte limit
        alu_req = '{op: ALU_SUB, a: ALU_W'(maxb_r), b: sum_r};
      end
      default: begin
        alu_req = '{op: ALU_ADD, a: '0, b: '0};
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    walk_nxt   = walk_r;
    cap_nxt    = cap_r;
    maxb_nxt   = maxb_r;
    cmd_nxt    = cmd_r;
    hdl_nxt    = hdl_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    lim_nxt    = lim_r;
    cnt_nxt    = cnt_r;
    stat_nxt   = stat_r;
    total_nxt  = total_r;
    sum_nxt    = sum_r;
    newrem_nxt = newrem_r;

    emit         = 1'b0;
    out_kind_nxt = KIND_SUM;
    out_stat_nxt = ST_OK;
    out_hdl_nxt  = '0;
    out_ofs_nxt  = '0;
    out_len_nxt  = '0;
    out_cnt_nxt  = '0;
    out_left_nxt = '0;
    out_last_nxt = 1'b0;

    mem_wr = '{en: 1'b0, addr: tail_r,
               data: '{handle: hdl_r, rem: len_r, ofs: '0}};
    mem_rd = '{en: 1'b0, addr: head_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = cmd_t'(in_chan.command);
          hdl_nxt   = HANDLE_WIDTH'(in_chan.packet_handle);
          len_nxt   = in_chan.packet_length;
          left_nxt  = in_chan.bytes_sent;
          lim_nxt   = in_chan.max_entries;
          cnt_nxt   = '0;
          stat_nxt  = ST_OK;
          total_nxt = '0;
          walk_nxt  = head_r;
          unique case (in_chan.command)
            CMD_PUSH:   state_nxt = S_PUSH;
            CMD_CPL:    state_nxt = S_CRD;
            CMD_GATHER: state_nxt = S_GRD;
            default:    state_nxt = S_SUM;
          endcase
        end
      end

      S_PUSH: begin
        // one slot stays free, so next tail meeting head means full
        if (next_slot(tail_r, cap_r) == head_r) begin
          stat_nxt = ST_FULL;
        end else begin
          mem_wr.en = 1'b1;
          tail_nxt  = next_slot(tail_r, cap_r);
        end
        state_nxt = S_SUM;
      end

      S_CRD: begin
        if (left_r == '0) begin
          state_nxt = S_SUM;
        end else if (head_r == tail_r) begin
          stat_nxt  = ST_UNDERRUN;
          state_nxt = S_SUM;
        end else begin
          mem_rd    = '{en: 1'b1, addr: head_r};
          state_nxt = S_CCMP;
        end
      end

      S_CCMP: begin
        if (alu_carry) begin
          state_nxt = S_CPART;
        end else begin
          left_nxt  = alu_res[BYTES_W-1:0];
          state_nxt = S_CREL;
        end
      end

      S_CPART: begin
        newrem_nxt = alu_res[LEN_W-1:0];
        state_nxt  = S_COFS;
      end

      S_COFS: begin
        mem_wr = '{en: 1'b1, addr: head_r,
                   data: '{handle: rd_data.handle, rem: newrem_r,
                           ofs: alu_res[LEN_W-1:0]}};
        left_nxt  = '0;
        state_nxt = S_SUM;
      end

      S_CREL: begin
        if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_REL;
          out_hdl_nxt  = HPORT_W'(rd_data.handle);
          out_ofs_nxt  = alu_res[LEN_W-1:0];
          cnt_nxt      = cnt_r + 1'b1;
          head_nxt     = next_slot(head_r, cap_r);
          state_nxt    = S_CRD;
        end
      end

      S_GRD: begin
        if ((walk_r == tail_r) || (cnt_r == lim_r)) begin
          state_nxt = S_SUM;
        end else begin
          mem_rd    = '{en: 1'b1, addr: walk_r};
          state_nxt = S_GSUM;
        end
      end

      S_GSUM: begin
        sum_nxt   = alu_res;
        state_nxt = S_GCHK;
      end

      S_GCHK: begin
        if (alu_carry) begin
          state_nxt = S_SUM;
        end else if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_DESC;
          out_hdl_nxt  = HPORT_W'(rd_data.handle);
          out_ofs_nxt  = rd_data.ofs;
          out_len_nxt  = rd_data.rem;
          total_nxt    = sum_r;
          cnt_nxt      = cnt_r + 1'b1;
          walk_nxt     = next_slot(walk_r, cap_r);
          state_nxt    = S_GRD;
        end
      end

      S_SUM: begin
        if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_SUM;
          out_stat_nxt = stat_r;
          out_cnt_nxt  = cnt_r;
          out_left_nxt = (stat_r == ST_UNDERRUN) ? left_r : '0;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register writes; capacity write empties the ring
    if (cfg_fire) begin
      unique case (cfg_chan.index)
        CFG_RING_CAP: begin
          if (cfg_cap < CFG_CAP_W'(2)) begin
            cap_nxt = CAP_W'(2);
          end else if (int'(cfg_cap) > RING_DEPTH) begin
            cap_nxt = CAP_W'(RING_DEPTH);
          end else begin
            cap_nxt = CAP_W'(cfg_cap);
          end
          head_nxt = '0;
          tail_nxt = '0;
        end
        CFG_MAX_BATCH: begin
          maxb_nxt = cfg_chan.data[LEN_W-1:0];
        end
        default: begin
          maxb_nxt = maxb_r;
        end
      endcase
    end

    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cap_r       <= CAP_W'(CAP_RST);
      maxb_r      <= MAX_BATCH_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cap_r       <= cap_nxt;
      maxb_r      <= maxb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    walk_r   <= walk_nxt;
    cmd_r    <= cmd_nxt;
    hdl_r    <= hdl_nxt;
    len_r    <= len_nxt;
    left_r   <= left_nxt;
    lim_r    <= lim_nxt;
    cnt_r    <= cnt_nxt;
    stat_r   <= stat_nxt;
    total_r  <= total_nxt;
    sum_r    <= sum_nxt;
    newrem_r <= newrem_nxt;
    if (emit) begin
      out_kind_r <= out_kind_nxt;
      out_stat_r <= out_stat_nxt;
      out_hdl_r  <= out_hdl_nxt;
      out_ofs_r  <= out_ofs_nxt;
      out_len_r  <= out_len_nxt;
      out_cnt_r  <= out_cnt_nxt;
      out_left_r <= out_left_nxt;
      out_last_r <= out_last_nxt;
    end
  end

`ifndef SYNTHESIS
  // pointers always stay inside the programmed ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CAP_W'(head_r) < cap_r) && (CAP_W'(tail_r) < cap_r))
    else $error("ring pointer beyond capacity");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r >= CAP_W'(2)) && (int'(cap_r) <= RING_DEPTH))
    else $error("capacity out of range");

  // an accepted request always occupies the sequencer for at least one step
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer idle right after request accept");

  // released packets come only from a complete request
  a_release_src: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (out_kind_nxt == KIND_REL)) |-> (cmd_r == CMD_CPL))
    else $error("release result outside complete");
`endif

endmodule

// File: bench/tx_descriptor_ring_byte_completion_tb.sv
`timescale 1ns / 1ps

module tx_descriptor_ring_byte_completion_tb;
  import trbc_pkg::*;

  // command code with no defined operation, must leave the ring alone
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;

  // one request on the input channel
  typedef struct {
    logic [CMD_W-1:0]   command;
    logic [HPORT_W-1:0] handle;
    logic [LEN_W-1:0]   length;
    logic [BYTES_W-1:0] sent;
    logic [ENT_W-1:0]   entries;
  } ring_req_t;

  // one result on the output channel
  typedef struct {
    kind_t              kind;
    status_t            status;
    logic [HPORT_W-1:0] handle;
    logic [LEN_W-1:0]   offset;
    logic [LEN_W-1:0]   length;
    logic [ENT_W-1:0]   count;
    logic [BYTES_W-1:0] leftover;
    logic               last;
  } ring_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  trbc_in_if  in_chan ();
  trbc_out_if out_chan ();
  trbc_cfg_if cfg_chan ();

  tx_descriptor_ring_byte_completion u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the ring and its registers
  logic [HANDLE_WIDTH-1:0] shadow_handle [RING_DEPTH];
  logic [LEN_W-1:0]        shadow_rem    [RING_DEPTH];
  logic [LEN_W-1:0]        shadow_ofs    [RING_DEPTH];
  int                      shadow_head;
  int                      shadow_tail;
  int                      shadow_cap;
  logic [LEN_W-1:0]        shadow_batch;

  ring_req_t pending_reqs[$];
  ring_res_t expected_results[$];

  ring_req_t tx_cur;
  int        tx_wait;
  int        rx_wait;
  bit        tx_gaps;
  bit        rx_gaps;
  bit        hold_arm;
  bit        hold_done;
  int        hold_left;
  int        mismatches;
  int        cycle_cnt;

  function automatic int ring_succ(input int idx);
    return (idx + 1 >= shadow_cap) ? 0 : idx + 1;
  endfunction

  function automatic ring_res_t mk_res(input kind_t kind, input status_t status,
                                       input logic [HPORT_W-1:0] handle,
                                       input logic [LEN_W-1:0] offset,
                                       input logic [LEN_W-1:0] length,
                                       input logic [ENT_W-1:0] count,
                                       input logic [BYTES_W-1:0] leftover,
                                       input logic last);
    ring_res_t r;
    r.kind = kind;
    r.status = status;
    r.handle = handle;
    r.offset = offset;
    r.length = length;
    r.count = count;
    r.leftover = leftover;
    r.last = last;
    return r;
  endfunction

  function automatic ring_req_t mk_req(input logic [CMD_W-1:0] command,
                                       input logic [HPORT_W-1:0] handle,
                                       input logic [LEN_W-1:0] length,
                                       input logic [BYTES_W-1:0] sent,
                                       input logic [ENT_W-1:0] entries);
    ring_req_t r;
    r.command = command;
    r.handle = handle;
    r.length = length;
    r.sent = sent;
    r.entries = entries;
    return r;
  endfunction

  // random request; len_hi sets the usual packet size, bytes scale with it
  function automatic ring_req_t rand_req(input int len_hi);
    ring_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.command = CMD_PUSH;
    else if (pick < 70) r.command = CMD_CPL;
    else if (pick < 95) r.command = CMD_GATHER;
    else r.command = CMD_UNKNOWN;
    r.handle = $urandom;
    case ($urandom_range(0, 7))
      0: r.length = '0;
      1: r.length = LEN_W'($urandom);
      default: r.length = LEN_W'($urandom_range(0, len_hi));
    endcase
    case ($urandom_range(0, 7))
      0: r.sent = '0;
      1: r.sent = BYTES_W'($urandom);
      default: r.sent = BYTES_W'($urandom_range(0, 3 * len_hi));
    endcase
    r.entries = ENT_W'($urandom_range(0, 63));
    return r;
  endfunction

  // work out the results one accepted request causes and update the shadow ring
  task automatic predict_ring(input ring_req_t r);
    int unsigned left;
    int unsigned total;
    int          released;
    int          n;
    int          p;
    int          h;
    bit          walking;
    status_t     st;
    if (shadow_head >= shadow_cap) shadow_head = 0;
    if (shadow_tail >= shadow_cap) shadow_tail = 0;
    st = ST_OK;
    case (r.command)
      CMD_PUSH: begin
        // one slot always stays free
        if (ring_succ(shadow_tail) == shadow_head) begin
          st = ST_FULL;
        end else begin
          shadow_handle[shadow_tail] = HANDLE_WIDTH'(r.handle);
          shadow_rem[shadow_tail] = r.length;
          shadow_ofs[shadow_tail] = '0;
          shadow_tail = ring_succ(shadow_tail);
        end
        expected_results.push_back(mk_res(KIND_SUM, st, '0, '0, '0, '0, '0, 1'b1));
      end
      CMD_CPL: begin
        left = r.sent;
        released = 0;
        walking = (left > 0);
        while (walking) begin
          h = shadow_head;
          if (h == shadow_tail) begin
            // bytes left with nothing queued
            st = ST_UNDERRUN;
            walking = 1'b0;
          end else if (left >= shadow_rem[h]) begin
            // whole packet done, zero-length ones go too while bytes remain
            left = left - shadow_rem[h];
            expected_results.push_back(mk_res(KIND_REL, ST_OK, HPORT_W'(shadow_handle[h]),
                                              shadow_ofs[h] + shadow_rem[h], '0, '0, '0,
                                              1'b0));
            released++;
            shadow_head = ring_succ(h);
            walking = (left > 0);
          end else begin
            shadow_rem[h] = shadow_rem[h] - LEN_W'(left);
            shadow_ofs[h] = shadow_ofs[h] + LEN_W'(left);
            left = 0;
            walking = 1'b0;
          end
        end
        expected_results.push_back(mk_res(KIND_SUM, st, '0, '0, '0, ENT_W'(released),
                                          (st == ST_UNDERRUN) ? BYTES_W'(left) : '0, 1'b1));
      end
      CMD_GATHER: begin
        n = 0;
        total = 0;
        p = shadow_head;
        walking = 1'b1;
        while (walking && p != shadow_tail && n < int'(r.entries)) begin
          if (total + shadow_rem[p] > shadow_batch) begin
            walking = 1'b0;
          end else begin
            expected_results.push_back(mk_res(KIND_DESC, ST_OK, HPORT_W'(shadow_handle[p]),
                                              shadow_ofs[p], shadow_rem[p], '0, '0, 1'b0));
            n++;
            total = total + shadow_rem[p];
            p = ring_succ(p);
          end
        end
        expected_results.push_back(mk_res(KIND_SUM, ST_OK, '0, '0, '0, ENT_W'(n), '0, 1'b1));
      end
      default: begin
        expected_results.push_back(mk_res(KIND_SUM, ST_OK, '0, '0, '0, '0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // driver: offers queued requests, random gap after each accepted one
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      offer = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        predict_ring(tx_cur);
        offer = 1'b0;
        tx_wait = tx_gaps ? $urandom_range(0, 5) : 0;
      end
      if (!offer) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_reqs.size() > 0) begin
          tx_cur = pending_reqs.pop_front();
          in_chan.command <= tx_cur.command;
          in_chan.packet_handle <= tx_cur.handle;
          in_chan.packet_length <= tx_cur.length;
          in_chan.bytes_sent <= tx_cur.sent;
          in_chan.max_entries <= tx_cur.entries;
          offer = 1'b1;
        end
      end
      in_chan.valid <= offer;
    end
  end

  // long receiver hold-off, fired once when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    ring_res_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending: kind %0h", out_chan.result_kind);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(out_chan.result_kind));
          check_field("status", 32'(want.status), 32'(out_chan.status));
          check_field("handle", 32'(want.handle), 32'(out_chan.handle));
          check_field("offset", 32'(want.offset), 32'(out_chan.offset));
          check_field("length", 32'(want.length), 32'(out_chan.length));
          check_field("count", 32'(want.count), 32'(out_chan.count));
          check_field("leftover_bytes", 32'(want.leftover), 32'(out_chan.leftover_bytes));
          check_field("last", 32'(want.last), 32'(out_chan.last));
        end
        rx_wait = rx_gaps ? $urandom_range(0, 5) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_chan.ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // wait until every request is taken and every result is back
  task automatic drain_ring();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_chan.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int c;
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk);
    while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    if (idx == CFG_RING_CAP) begin
      // low 7 bits, then clamped; the ring empties
      c = int'(val & 16'h007F);
      if (c < 2) c = 2;
      if (c > RING_DEPTH) c = RING_DEPTH;
      shadow_cap = c;
      shadow_head = 0;
      shadow_tail = 0;
    end else begin
      shadow_batch = val;
    end
  endtask

  task automatic queue_random(input int n, input int len_hi);
    repeat (n) pending_reqs.push_back(rand_req(len_hi));
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.command = '0;
    in_chan.packet_handle = '0;
    in_chan.packet_length = '0;
    in_chan.bytes_sent = '0;
    in_chan.max_entries = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_arm = 1'b0;
    mismatches = 0;
    cycle_cnt = 0;
    shadow_head = 0;
    shadow_tail = 0;
    shadow_cap = CAP_RST;
    shadow_batch = MAX_BATCH_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset settings
    // empty ring: gather, zero-byte complete, underrun, unknown command
    pending_reqs.push_back(mk_req(CMD_GATHER, $urandom, '0, '0, 6'd63));
    pending_reqs.push_back(mk_req(CMD_CPL, '0, '0, '0, '0));
    pending_reqs.push_back(mk_req(CMD_CPL, '0, '0, 22'd5, '0));
    pending_reqs.push_back(mk_req(CMD_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF, 22'h3F_FFFF, 6'h3F));
    // largest packet, zero-length packet, ordinary one
    pending_reqs.push_back(mk_req(CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF, '0, '0));
    pending_reqs.push_back(mk_req(CMD_PUSH, 32'h0000_0000, 16'd0, '0, '0));
    pending_reqs.push_back(mk_req(CMD_PUSH, $urandom, 16'd100, '0, '0));
    // gather with no entries allowed, then head larger than the batch limit
    pending_reqs.push_back(mk_req(CMD_GATHER, '0, '0, '0, 6'd0));
    pending_reqs.push_back(mk_req(CMD_GATHER, '0, '0, '0, 6'd63));
    // zero bytes retire nothing, not even the zero-length packet
    pending_reqs.push_back(mk_req(CMD_CPL, '0, '0, '0, '0));
    // partial send, then exact finish of the head packet
    pending_reqs.push_back(mk_req(CMD_CPL, '0, '0, 22'd1000, '0));
    pending_reqs.push_back(mk_req(CMD_GATHER, '0, '0, '0, 6'd63));
    pending_reqs.push_back(mk_req(CMD_CPL, '0, '0, 22'd64535, '0));
    // one byte retires the zero-length packet and starts the next
    pending_reqs.push_back(mk_req(CMD_CPL, '0, '0, 22'd1, '0));
    pending_reqs.push_back(mk_req(CMD_GATHER, '0, '0, '0, 6'd63));
    // largest byte count: release and underrun
    pending_reqs.push_back(mk_req(CMD_CPL, '0, '0, 22'h3F_FFFF, '0));
    pending_reqs.push_back(mk_req(CMD_PUSH, 32'hA5A5_5A5A, 16'h5A5A, 22'h2A_AAAA, 6'h2A));
    pending_reqs.push_back(mk_req(CMD_PUSH, 32'h5A5A_A5A5, 16'hA5A5, 22'h15_5555, 6'h15));
    pending_reqs.push_back(mk_req(CMD_GATHER, '0, '0, '0, 6'd1));
    pending_reqs.push_back(mk_req(CMD_CPL, '0, '0, 22'd23130, '0));
    drain_ring();

    // capacity below range clamps to two, one packet fits
    write_reg(CFG_RING_CAP, 16'h0001);
    write_reg(CFG_MAX_BATCH, 16'hFFFF);
    queue_random(12, 1500);
    drain_ring();

    // upper data bits ignored, capacity five; zero batch limit
    write_reg(CFG_RING_CAP, 16'hFF05);
    write_reg(CFG_MAX_BATCH, 16'h0000);
    queue_random(12, 200);
    drain_ring();

    // capacity above range clamps to the full depth; fill the ring and drain it
    write_reg(CFG_RING_CAP, 16'h007F);
    write_reg(CFG_MAX_BATCH, 16'hFFFF);
    repeat (66) pending_reqs.push_back(mk_req(CMD_PUSH, $urandom,
                                              LEN_W'($urandom_range(0, 300)), '0, '0));
    pending_reqs.push_back(mk_req(CMD_GATHER, '0, '0, '0, 6'd63));
    pending_reqs.push_back(mk_req(CMD_GATHER, '0, '0, '0, 6'd7));
    pending_reqs.push_back(mk_req(CMD_CPL, '0, '0, 22'h3F_FFFF, '0));
    drain_ring();

    // batch limit one with tiny packets
    write_reg(CFG_MAX_BATCH, 16'h0001);
    queue_random(20, 3);
    drain_ring();

    // no idling on either side
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_reg(CFG_RING_CAP, 16'h0003);
    write_reg(CFG_MAX_BATCH, MAX_BATCH_RST);
    queue_random(20, 1000);
    drain_ring();

    // receiver holds off while the sender keeps offering requests
    write_reg(CFG_RING_CAP, 16'h0041);
    write_reg(CFG_MAX_BATCH, 16'($urandom));
    hold_arm = 1'b1;
    rx_gaps = 1'b1;
    queue_random(30, 800);
    drain_ring();
    tx_gaps = 1'b1;

    // capacity wraps to zero in the low bits, then a mid size ring
    write_reg(CFG_RING_CAP, 16'h0080);
    write_reg(CFG_MAX_BATCH, 16'h8000);
    queue_random(8, 1500);
    drain_ring();
    write_reg(CFG_RING_CAP, 16'h0011);
    queue_random(12, 1500);
    drain_ring();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
